// File: hw/rtl/tps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tps_pkg
// Shared widths, codes and helpers of the timer prescaler solver.
// ---------------------------------------------------------------------------
package tps_pkg;

    localparam int FREQ_FRAC_BITS = 8;
    localparam int MAX_TIMER_BITS = 32;

    localparam int TW      = 39;                    // target field
    localparam int MHZ_W   = 12;
    localparam int BITS_W  = 6;
    localparam int XW      = 32 + FREQ_FRAC_BITS;   // cpu clock in Hz, scaled
    localparam int YW      = XW + 3;                // chosen divisor, below 8*x
    localparam int PW      = TW + 10 + MAX_TIMER_BITS;
    localparam int CMP_W   = 32;
    localparam int SEL_W   = 3;
    localparam int PDW     = CMP_W + 10;            // compare times prescaler
    localparam int FQW     = 39;
    localparam int PERW    = 32;
    localparam int FNUM_W  = ((XW + 1 > PDW) ? XW + 1 : PDW) + 1;
    localparam int PNUM_W  = PDW + 11;
    localparam int DIVN_W  = (FNUM_W > PNUM_W) ? FNUM_W : PNUM_W;
    localparam int NPRESC  = 7;
    localparam int CFG_IDX_W = 2;

    localparam int OUT_BITS    = 2 + SEL_W + CMP_W + FQW + PERW;
    localparam int IN_TDATA_W  = ((TW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [19:0] HZ_PER_MHZ = 20'd1000000;
    localparam logic [XW-1:0] X_RESET = XW'(64'd16000000 << FREQ_FRAC_BITS);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOW  = 2'd1,
        ST_HIGH = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_FREQ    = 2'd0,
        CFG_TIMER_WIDTH = 2'd1
    } t_cfg_idx;

    // prescaler index 0..6 -> log2 of 1,8,32,64,128,256,1024
    function automatic logic [3:0] presc_shift(input logic [SEL_W-1:0] idx);
        logic [3:0] s;
        unique case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd3;
            3'd2:    s = 4'd5;
            3'd3:    s = 4'd6;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tps_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tps_div_cell
// One restoring division step: brings down one numerator bit, subtracts the
// divisor when it fits and shifts the quotient bit in.
// ---------------------------------------------------------------------------
module tps_div_cell
    import tps_pkg::*;
#(
    parameter int N = 8,
    parameter int D = 8,
    parameter int W = 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  wire  [D-1:0] i_rem,
    input  wire  [N-1:0] i_nq,     // numerator bits on top, quotient bits below
    input  wire  [D-1:0] i_div,
    input  wire  [W-1:0] i_pay,
    output logic         o_valid,
    output logic [D-1:0] o_rem,
    output logic [N-1:0] o_nq,
    output logic [D-1:0] o_div,
    output logic [W-1:0] o_pay
);

    logic [D:0]   trial;
    logic [D+1:0] diff;
    logic         ge;

    assign trial = {i_rem, i_nq[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, i_div};
    assign ge    = ~diff[D+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= ge ? diff[D-1:0] : trial[D-1:0];
            o_nq  <= {i_nq[N-2:0], ge};
            o_div <= i_div;
            o_pay <= i_pay;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tps_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tps_divider
// Pipelined unsigned divider: a row of N division cells, one quotient bit
// each, with a side payload that travels alongside.
// ---------------------------------------------------------------------------
module tps_divider
    import tps_pkg::*;
#(
    parameter int N = 8,
    parameter int D = 8,
    parameter int W = 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  wire  [N-1:0] i_num,
    input  wire  [D-1:0] i_div,
    input  wire  [W-1:0] i_pay,
    output logic         o_valid,
    output logic [N-1:0] o_quo,
    output logic [D-1:0] o_rem,
    output logic [D-1:0] o_div,
    output logic [W-1:0] o_pay
);

    logic         w_valid [0:N];
    logic [D-1:0] w_rem   [0:N];
    logic [N-1:0] w_nq    [0:N];
    logic [D-1:0] w_div   [0:N];
    logic [W-1:0] w_pay   [0:N];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_nq[0]    = i_num;
    assign w_div[0]   = i_div;
    assign w_pay[0]   = i_pay;

    for (genvar g = 0; g < N; g++) begin : g_cell
        tps_div_cell #(.N(N), .D(D), .W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_nq    (w_nq[g]),
            .i_div   (w_div[g]),
            .i_pay   (w_pay[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_nq    (w_nq[g+1]),
            .o_div   (w_div[g+1]),
            .o_pay   (w_pay[g+1])
        );
    end

    assign o_valid = w_valid[N];
    assign o_quo   = w_nq[N];
    assign o_rem   = w_rem[N];
    assign o_div   = w_div[N];
    assign o_pay   = w_pay[N];

endmodule
`default_nettype wire

// File: hw/rtl/timer_prescaler_compare_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// timer_prescaler_compare_solver
// Picks a counter prescaler and compare value for a requested frequency.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one target frequency (Hz, 8 fractional bits) per transfer.
//   m_axis returns one result per target: status, clock select, compare
//   value, achieved frequency and achieved period.
//   The cfg channel writes cpu_freq_mhz (index 0) or timer_width_bits
//   (index 1); it is always ready and takes effect on the next cycle.
//   Write it only while no target is in flight.
// Pipeline:
//   From input transfer to result valid a target passes three setup
//   stages, a 40-cell divider for the compare value, two stages, and two
//   53-cell dividers in parallel for frequency and period, then the output
//   register. One target is taken every cycle while the output is not stalled.
// Reset and stall:
//   Reset empties the pipeline and loads 16 MHz and an 8-bit counter.
//   While a result sits in the output register and is not taken, the whole
//   pipeline holds and s_axis tready is low.
// ---------------------------------------------------------------------------
module timer_prescaler_compare_solver
    import tps_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // target_freq_q8 [38:0]
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // status [1:0], clock_select [4:2], compare_value [36:5],
    // real_freq_q8 [75:37], real_period_ns [107:76]
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [MHZ_W-1:0]        i_cfg_data
);

    // ---------------- configuration ----------------
    logic [MHZ_W-1:0]  r_mhz;      // zero already mapped to one
    logic [BITS_W-1:0] r_bits;
    logic [XW-1:0]     r_x;
    logic [MHZ_W-1:0]  cfg_mhz;
    logic [BITS_W-1:0] bits_c;

    assign o_cfg_ready = 1'b1;
    assign cfg_mhz = (i_cfg_data == '0) ? MHZ_W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mhz  <= MHZ_W'(16);
            r_bits <= BITS_W'(8);
            r_x    <= X_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CPU_FREQ: begin
                    r_mhz <= cfg_mhz;
                    r_x   <= XW'({32'(cfg_mhz) * 32'(HZ_PER_MHZ), FREQ_FRAC_BITS'(0)});
                end
                CFG_TIMER_WIDTH: r_bits <= i_cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_bits == '0) begin
            bits_c = BITS_W'(1);
        end else if (r_bits > BITS_W'(MAX_TIMER_BITS)) begin
            bits_c = BITS_W'(MAX_TIMER_BITS);
        end else begin
            bits_c = r_bits;
        end
    end

    // ---------------- pipeline control ----------------
    logic r_out_valid;
    logic en;

    assign en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---------------- stage A: input register ----------------
    logic          r_a_valid;
    logic [TW-1:0] r_a_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_t <= i_s_axis_tdata[TW-1:0];
        end
    end

    // ---------------- stage B: t * m * prescaler, saturated ----------------
    logic          r_b_valid;
    logic [TW-1:0] r_b_t;
    logic [XW:0]   r_b_p [0:NPRESC-1];
    logic [XW:0]   n_b_p [0:NPRESC-1];

    for (genvar g = 0; g < NPRESC; g++) begin : g_prod
        logic [PW-1:0] t_ext;
        logic [PW-1:0] diff;
        logic [6:0]    sa;
        assign t_ext = PW'(r_a_t);
        assign sa    = 7'(presc_shift(SEL_W'(g))) + 7'(bits_c);
        assign diff  = (t_ext << sa) - (t_ext << presc_shift(SEL_W'(g)));
        assign n_b_p[g] = (|diff[PW-1:XW]) ? '1 : {1'b0, diff[XW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_t <= r_a_t;
            r_b_p <= n_b_p;
        end
    end

    // ---------------- stage C: range check and prescaler pick ----------------
    logic             r_c_valid;
    t_status          r_c_status;
    logic [SEL_W-1:0] r_c_code;
    logic [YW-1:0]    r_c_y;
    t_status          n_c_status;
    logic [SEL_W-1:0] c_idx;

    always_comb begin
        c_idx = SEL_W'(NPRESC - 1);
        for (int i = NPRESC - 2; i >= 0; i--) begin
            if ({1'b0, r_x} <= r_b_p[i]) begin
                c_idx = SEL_W'(i);
            end
        end
    end

    always_comb begin
        priority if (r_b_p[NPRESC-1] < {1'b0, r_x}) begin
            n_c_status = ST_LOW;
        end else if (XW'(r_b_t) > r_x) begin
            n_c_status = ST_HIGH;
        end else begin
            n_c_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_status <= n_c_status;
            r_c_code   <= c_idx + SEL_W'(1);
            r_c_y      <= YW'(r_b_t) << presc_shift(c_idx);
        end
    end

    // ---------------- compare value divider ----------------
    logic                 d1_valid;
    logic [XW-1:0]        d1_quo;
    logic [YW-1:0]        d1_rem;
    logic [YW-1:0]        d1_div;
    logic [SEL_W+1:0]     d1_pay;

    tps_divider #(.N(XW), .D(YW), .W(SEL_W + 2)) u_div_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_num   (r_x),
        .i_div   (r_c_y),
        .i_pay   ({r_c_code, r_c_status}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_div   (d1_div),
        .o_pay   (d1_pay)
    );

    // ---------------- stage E: rounding ----------------
    logic             r_e_valid;
    t_status          r_e_status;
    logic [SEL_W-1:0] r_e_code;
    logic [CMP_W-1:0] r_e_cmp;
    logic [PDW-1:0]   r_e_pdiv;
    logic [XW:0]      e_sum;
    logic [CMP_W-1:0] e_cmp;
    logic [SEL_W-1:0] e_code;

    assign e_code = d1_pay[SEL_W+1:2];
    assign e_sum  = {1'b0, d1_quo} + (XW + 1)'({d1_rem, 1'b0} >= {1'b0, d1_div});
    assign e_cmp  = (|e_sum[XW:CMP_W]) ? '1 : e_sum[CMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_status <= t_status'(d1_pay[1:0]);
            r_e_code   <= e_code;
            r_e_cmp    <= e_cmp;
            r_e_pdiv   <= PDW'(e_cmp) << presc_shift(e_code - SEL_W'(1));
        end
    end

    // ---------------- stage F: numerators ----------------
    logic             r_f_valid;
    t_status          r_f_status;
    logic [SEL_W-1:0] r_f_code;
    logic [CMP_W-1:0] r_f_cmp;
    logic [DIVN_W-1:0] r_f_fnum;
    logic [PDW:0]     r_f_fdiv;
    logic [DIVN_W-1:0] r_f_pnum;
    logic [DIVN_W-1:0] f_pd;

    assign f_pd = DIVN_W'(r_e_pdiv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_status <= r_e_status;
            r_f_code   <= r_e_code;
            r_f_cmp    <= r_e_cmp;
            r_f_fnum   <= DIVN_W'({r_x, 1'b0}) + f_pd;
            r_f_fdiv   <= {r_e_pdiv, 1'b0};
            // pdiv * 2000 + mhz
            r_f_pnum   <= (f_pd << 11) - (f_pd << 5) - (f_pd << 4) + DIVN_W'(r_mhz);
        end
    end

    // ---------------- frequency and period dividers ----------------
    logic                    d2_valid;
    logic [DIVN_W-1:0]       d2_quo;
    logic [PDW:0]            d2_rem;
    logic [PDW:0]            d2_div;
    logic [CMP_W+SEL_W+1:0]  d2_pay;
    logic [DIVN_W-1:0]       d3_quo;
    logic [MHZ_W:0]          d3_rem;
    logic [MHZ_W:0]          d3_div;
    logic                    d3_pay;

    tps_divider #(.N(DIVN_W), .D(PDW + 1), .W(CMP_W + SEL_W + 2)) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_valid),
        .i_num   (r_f_fnum),
        .i_div   (r_f_fdiv),
        .i_pay   ({r_f_cmp, r_f_code, r_f_status}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_div   (d2_div),
        .o_pay   (d2_pay)
    );

    tps_divider #(.N(DIVN_W), .D(MHZ_W + 1), .W(1)) u_div_period (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_valid),
        .i_num   (r_f_pnum),
        .i_div   ({r_mhz, 1'b0}),
        .i_pay   (r_f_status == ST_OK),
        .o_valid (),
        .o_quo   (d3_quo),
        .o_rem   (d3_rem),
        .o_div   (d3_div),
        .o_pay   (d3_pay)
    );

    // ---------------- output register ----------------
    t_status          r_out_status;
    logic [SEL_W-1:0] r_out_code;
    logic [CMP_W-1:0] r_out_cmp;
    logic [FQW-1:0]   r_out_freq;
    logic [PERW-1:0]  r_out_period;
    logic             o_ok;
    logic [FQW-1:0]   o_freq;
    logic [PERW-1:0]  o_period;

    assign o_ok     = d3_pay;
    assign o_freq   = (|d2_quo[DIVN_W-1:FQW]) ? '1 : d2_quo[FQW-1:0];
    assign o_period = (|d3_quo[DIVN_W-1:PERW]) ? '1 : d3_quo[PERW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status <= t_status'(d2_pay[1:0]);
            r_out_code   <= o_ok ? d2_pay[SEL_W+1:2] : '0;
            r_out_cmp    <= o_ok ? d2_pay[CMP_W+SEL_W+1:SEL_W+2] : '0;
            r_out_freq   <= o_ok ? o_freq : '0;
            r_out_period <= o_ok ? o_period : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_period, r_out_freq, r_out_cmp,
                                           r_out_code, r_out_status});

`ifndef NO_ASSERTIONS
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
        (r_out_code == '0 && r_out_cmp == '0 && r_out_freq == '0 && r_out_period == '0))
        else $error("error result carries nonzero fields");

    a_ok_has_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK) |-> (r_out_code != '0))
        else $error("ok result without a prescaler select");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_status == ST_OK) |-> (r_c_y != '0))
        else $error("zero divisor on an in-range target");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_cmp)))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Prescaler solver testbench: drives targets under random idling and
// register settings, and checks each result against a bit-exact predictor.
// ---------------------------------------------------------------------------

class solver_scoreboard;
    logic [1:0]  st_q[$];
    logic [2:0]  sel_q[$];
    logic [31:0] cmp_q[$];
    logic [38:0] frq_q[$];
    logic [31:0] per_q[$];
    int          errors;

    function void note_target(logic [38:0] t, logic [11:0] mhz_reg, logic [5:0] bits_reg);
        logic [63:0] mhz, m, x, y, q, r, cmp, pdiv, frq, per;
        int          bits, i;
        logic [3:0]  sh[7];
        sh = '{0, 3, 5, 6, 7, 8, 10};
        mhz = (mhz_reg == 0) ? 64'd1 : 64'(mhz_reg);
        bits = (bits_reg < 1) ? 1 : (bits_reg > 32) ? 32 : int'(bits_reg);
        m = (64'd1 << bits) - 1;
        x = (mhz * 64'd1000000) << 8;
        if ((64'(t) << 10) <= (x - 1) / m) begin
            push(tps_pkg::ST_LOW, 0, 0, 0, 0);
            return;
        end
        if (64'(t) > x) begin
            push(tps_pkg::ST_HIGH, 0, 0, 0, 0);
            return;
        end
        for (i = 0; i < 7; i++) begin
            y = 64'(t) << sh[i];
            q = x / y;
            r = x % y;
            if (i == 6 || !(q > m || (q == m && r > 0))) break;
        end
        cmp = q + ((2 * r >= y) ? 1 : 0);
        if (cmp > 64'hFFFF_FFFF) cmp = 64'hFFFF_FFFF;
        pdiv = cmp << sh[i];
        if (pdiv == 0) begin
            frq = (64'd1 << 39) - 1;
            per = 0;
        end else begin
            frq = (2 * x + pdiv) / (2 * pdiv);
            if (frq > (64'd1 << 39) - 1) frq = (64'd1 << 39) - 1;
            per = (2 * pdiv * 1000 + mhz) / (2 * mhz);
            if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
        end
        push(tps_pkg::ST_OK, 3'(i + 1), cmp[31:0], frq[38:0], per[31:0]);
    endfunction

    function void push(logic [1:0] s, logic [2:0] c, logic [31:0] v, logic [38:0] f,
                       logic [31:0] p);
        st_q.push_back(s);
        sel_q.push_back(c);
        cmp_q.push_back(v);
        frq_q.push_back(f);
        per_q.push_back(p);
    endfunction

    function void check_result(logic [107:0] d);
        logic [107:0] exp_d;
        if (st_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
        end
        exp_d = {per_q.pop_front(), frq_q.pop_front(), cmp_q.pop_front(),
                 sel_q.pop_front(), st_q.pop_front()};
        if (d[1:0] != exp_d[1:0])
            $display("%0t: status exp %0d got %0d", $time, exp_d[1:0], d[1:0]);
        if (d[4:2] != exp_d[4:2])
            $display("%0t: clock_select exp %0d got %0d", $time, exp_d[4:2], d[4:2]);
        if (d[36:5] != exp_d[36:5])
            $display("%0t: compare exp %0d got %0d", $time, exp_d[36:5], d[36:5]);
        if (d[75:37] != exp_d[75:37])
            $display("%0t: freq exp %0d got %0d", $time, exp_d[75:37], d[75:37]);
        if (d[107:76] != exp_d[107:76])
            $display("%0t: period exp %0d got %0d", $time, exp_d[107:76], d[107:76]);
        if (d[107:0] != exp_d) errors++;
    endfunction

    function int pending();
        return st_q.size();
    endfunction
endclass

module tb_top;
    import tps_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_CPU_FREQ;
    logic [MHZ_W-1:0]       cfg_data = '0;

    solver_scoreboard sb = new();
    logic [11:0] cur_mhz = 12'd16;
    logic [5:0]  cur_bits = 6'd8;
    int          send_idle = 0;   // percent
    int          recv_stall = 0;  // percent
    int          hold_off = 0;    // cycles of forced stall

    always #10 i_clk = ~i_clk;

    timer_prescaler_compare_solver i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // result side: random stall plus an optional long hold-off
    always @(posedge i_clk) begin
        if (m_valid && m_ready) sb.check_result(m_data[107:0]);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // tvalid stays up after a transfer; the next idle cycle or drain drops it
    task automatic send_target(logic [38:0] t);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= IN_TDATA_W'(t);
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_target(t, cur_mhz, cur_bits);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CPU_FREQ) cur_mhz = v;
        else cur_bits = v[5:0];
        @(posedge i_clk);
    endtask

    // targets spread over the range that reaches the ok status, plus noise
    function automatic logic [38:0] pick_target();
        logic [63:0] x, t;
        int          k;
        x = ((cur_mhz == 0 ? 64'd1 : 64'(cur_mhz)) * 64'd1000000) << 8;
        k = $urandom_range(99);
        if (k < 10) return 39'({$urandom(), $urandom()});
        if (k < 15) return 39'($urandom_range(3));
        if (k < 20) return 39'(x + $urandom_range(2));
        t = x >> $urandom_range(0, 44);
        t = t + ({$urandom(), $urandom()} % (t + 1));
        return t[38:0];
    endfunction

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [11:0] mhz_set[6];
        logic [5:0]  bit_set[6];
        int          ph;
        mhz_set = '{12'd16, 12'd1, 12'd4095, 12'd0, 12'd2147, 12'd20};
        bit_set = '{6'd8, 6'd1, 6'd32, 6'd2, 6'd63, 6'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and special cases at reset settings
        send_target(39'd0);
        send_target(39'd1);
        send_target(39'h7F_FFFF_FFFF);
        send_target(39'd4096000000);
        send_target(39'd4096000001);
        send_target(39'd4096000000 / 255);
        send_target(39'd62500 * 256);
        send_target(39'd1000 * 256);
        send_target(39'd61 * 256);
        send_target(39'd62 * 256);
        drain();
        write_reg(CFG_TIMER_WIDTH, 12'd1);
        send_target(39'd4096000000);
        send_target(39'd4096000000 / 3);
        send_target(39'd4096000000 / 2);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            write_reg(CFG_CPU_FREQ, mhz_set[ph % 6]);
            write_reg(CFG_TIMER_WIDTH, 12'(bit_set[(ph + 2) % 6]));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 63; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 63; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            if (ph == 4) hold_off = 400;
            repeat (250) send_target(pick_target());
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
